// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the design files.
// Each macro names a concurrent assertion clocked on clk_i with reset rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/elrg_pkg.sv =====
// Package for the edge-locked reference generator.
// Holds the request and result types, sizes, codes and the quarter-sine table.
`timescale 1ns / 1ps

package elrg_pkg;

  localparam int PeriodBits = 16;
  localparam int QueueDepth = 16;
  localparam int QueueAw = $clog2(QueueDepth);
  localparam int SineBits = 10;
  localparam int Quarter = 1 << (SineBits - 2);

  localparam logic [0:0] OpFeed = 1'b0;
  localparam logic [0:0] OpPull = 1'b1;

  localparam logic [1:0] KindPeriod = 2'd0;
  localparam logic [1:0] KindWave = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;

  localparam logic [1:0] ShapeSine = 2'd0;
  localparam logic [1:0] ShapeCosine = 2'd1;
  localparam logic [1:0] ShapeSquare = 2'd2;
  localparam logic [1:0] ShapeTriangle = 2'd3;

  typedef struct packed {
    logic [0:0]   op;
    logic signed [15:0] sample;
    logic signed [15:0] threshold;
  } req_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [15:0]  period;
    logic         dropped;
    logic signed [15:0] wave;
    logic         last_of_period;
  } rsp_t;

  // Quarter sine in Q15 at step r of a quarter cycle. A Q30 Taylor series with
  // truncated products and terms, rounded to Q15 and clipped to 0..32767.
  function automatic logic [14:0] quarter_sine_calc(input int unsigned r_in);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x = (64'd3373259426 * 64'(r_in)) >> (SineBits - 1);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return sum[14:0];
  endfunction

  // Packed table of the first Quarter points, 15 bits each.
  function automatic logic [Quarter*15-1:0] sine_table_calc();
    logic [Quarter*15-1:0] tab;
    tab = '0;
    for (int i = 0; i < Quarter; i++) tab[i*15 +: 15] = quarter_sine_calc(i);
    return tab;
  endfunction

  localparam logic [Quarter*15-1:0] SineTable = sine_table_calc();

  // Table lookup; the top of the quarter is full scale.
  function automatic logic [14:0] quarter_sine(input logic [SineBits-2:0] r_in);
    logic [14:0] v;
    if (r_in == (SineBits-1)'(Quarter)) v = 15'd32767;
    else v = SineTable[r_in[SineBits-3:0]*15 +: 15];
    return v;
  endfunction

  // Full sine at table index k, signed Q15.
  function automatic logic signed [15:0] table_sine(input logic [SineBits-1:0] k);
    logic [1:0] q;
    logic [SineBits-3:0] r;
    logic [SineBits-2:0] rr;
    logic [15:0] v;
    q = k[SineBits-1:SineBits-2];
    r = k[SineBits-3:0];
    if (q[0]) rr = (SineBits-1)'(Quarter) - {1'b0, r};
    else rr = {1'b0, r};
    v = {1'b0, quarter_sine(rr)};
    return q[1] ? -$signed(v) : $signed(v);
  endfunction

endpackage

// ===== hdl/edge_locked_reference_generator_unit.sv =====
// Edge-locked reference generator, top level.
// Depends on elrg_pkg and assert_macros.svh.
// Usage:
//  The request channel carries op, sample and threshold. A feed request
//  (op 0) compares sample with threshold; on a rising crossing it returns a
//  period report and queues the period unless it is zero or the queue is full.
//  A pull request (op 1) returns the next reference sample of the head period
//  in the shape held in shape_q, or an empty code when nothing is queued.
//  Periods live in a 16-entry synchronous memory with a registered read.
//  A feed without a crossing gives no result. Any other feed and an empty
//  pull show the result the cycle after acceptance. A pull with a queued
//  period passes through StRead, which loads the divider, then 35 steps of a
//  restoring divider (one per dividend bit) that form the table index or the
//  triangle value from (2j+1)/(2P), then StFinish, which forms the sample.
//  One request is in work at a time. The result waits in an output register;
//  while the receiver stalls the block holds it and takes no new request.
//  Reset clears all control state, the shape register and the queue
//  pointers; queue contents need no clearing.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module edge_locked_reference_generator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_stall_o,
  input  elrg_pkg::req_t       req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_stall_i,
  output elrg_pkg::rsp_t       rsp_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle, StRead, StDivide, StFinish, StOut
  } state_e;

  localparam int Aw = elrg_pkg::QueueAw;
  localparam int Pb = elrg_pkg::PeriodBits;
  // Dividend t*2^17 needs Pb+18 bits; quotient up to 17 bits covers both uses.
  localparam int Qb = 18;
  localparam int Nb = Pb + 1 + Qb;

  state_e state_q;
  logic [1:0] shape_q;
  logic was_above_q;
  logic [Pb-1:0] count_q;
  logic [Aw-1:0] head_q;
  logic [Aw:0] fill_q;
  logic [Pb-1:0] pos_q;
  elrg_pkg::rsp_t rsp_q;
  logic [Pb-1:0] mem [elrg_pkg::QueueDepth];
  logic [Pb-1:0] rd_q;
  logic [Pb:0] t_q;
  logic [Pb+1:0] rem_q;
  logic [Qb-1:0] quo_q;
  logic [Nb-1:0] num_q;
  logic [5:0] step_q;
  logic accept;

  assign accept = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != StIdle);
  assign rsp_valid_o = (state_q == StOut);
  assign rsp_o = rsp_q;

  // Queue memory: one write port, registered read of the head entry.
  logic mem_we;
  logic [Aw-1:0] mem_wa;
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= count_q;
    end
    rd_q <= mem[head_q];
  end

  // Feed path decisions.
  logic above, edge_hit, queue_full;
  assign above = req_i.sample > req_i.threshold;
  assign edge_hit = above && !was_above_q;
  assign queue_full = (fill_q == (Aw+1)'(elrg_pkg::QueueDepth));
  assign mem_wa = head_q + fill_q[Aw-1:0];
  assign mem_we = accept && req_i.op == elrg_pkg::OpFeed && edge_hit &&
                  count_q != '0 && !queue_full;

  // Divider remainder step.
  logic [Pb+2:0] trial;
  logic [Pb+1:0] dvs;
  assign dvs = {rd_q, 1'b0};
  assign trial = {rem_q, num_q[Nb-1]} - {1'b0, dvs};

  // Result formation after the divide.
  logic [Pb+1:0] t2;
  logic signed [15:0] wv;
  logic last;
  logic [Qb-1:0] u;
  logic signed [Qb+1:0] tv;
  always_comb begin
    t2 = {t_q, 1'b0};
    last = ({1'b0, pos_q} + 1'b1) >= {1'b0, rd_q};
    // Triangle quotient rounds ties up: remainder*2 >= divisor.
    u = quo_q + Qb'({rem_q, 1'b0} >= {1'b0, dvs});
    tv = '0;
    wv = '0;
    case (shape_q)
      elrg_pkg::ShapeSine: wv = elrg_pkg::table_sine(quo_q[elrg_pkg::SineBits-1:0]);
      elrg_pkg::ShapeCosine: wv = elrg_pkg::table_sine(
          quo_q[elrg_pkg::SineBits-1:0] + elrg_pkg::SineBits'(elrg_pkg::Quarter));
      elrg_pkg::ShapeSquare: begin
        if ({1'b0, t_q} < {1'b0, rd_q}) wv = 16'sd32767;
        else if ({1'b0, t_q} == {1'b0, rd_q}) wv = '0;
        else wv = -16'sd32768;
      end
      default: begin
        if ({t2, 1'b0} < {2'b0, dvs}) tv = $signed({2'b0, u});
        else if ({t2, 1'b0} < 2'd3 * {2'b0, dvs}) tv = 20'sd65536 - $signed({2'b0, u});
        else tv = $signed({2'b0, u}) - 20'sd131072;
        if (tv > 20'sd32767) wv = 16'sd32767;
        else if (tv < -20'sd32768) wv = -16'sd32768;
        else wv = tv[15:0];
      end
    endcase
  end

  // Control state, registered result and divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      shape_q <= '0;
      was_above_q <= 1'b0;
      count_q <= '0;
      head_q <= '0;
      fill_q <= '0;
      pos_q <= '0;
      step_q <= '0;
      rsp_q <= '0;
      t_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      num_q <= '0;
    end else begin
      if (cfg_we_i) shape_q <= cfg_data_i;
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (req_i.op == elrg_pkg::OpFeed) begin
              was_above_q <= above;
              if (edge_hit) begin
                rsp_q <= '{kind: elrg_pkg::KindPeriod, period: count_q[15:0],
                           dropped: (count_q != '0) && queue_full, wave: '0,
                           last_of_period: 1'b0};
                if (count_q != '0 && !queue_full) fill_q <= fill_q + 1'b1;
                count_q <= Pb'(1);
                state_q <= StOut;
              end else if (count_q != '1) begin
                count_q <= count_q + 1'b1;
              end
            end else if (fill_q == '0) begin
              rsp_q <= '{kind: elrg_pkg::KindEmpty, period: '0, dropped: 1'b0,
                         wave: '0, last_of_period: 1'b0};
              state_q <= StOut;
            end else begin
              state_q <= StRead;
            end
          end
        end
        StRead: begin
          t_q <= {pos_q, 1'b1};
          state_q <= StDivide;
          step_q <= '0;
          rem_q <= '0;
          quo_q <= '0;
          // Sine index uses t*2^SineBits; triangle uses t*2^17.
          if (shape_q == elrg_pkg::ShapeTriangle)
            num_q <= Nb'({{pos_q, 1'b1}, 17'b0});
          else
            num_q <= Nb'({{pos_q, 1'b1}, elrg_pkg::SineBits'(0)});
        end
        StDivide: begin
          num_q <= {num_q[Nb-2:0], 1'b0};
          if (!trial[Pb+2]) begin
            rem_q <= trial[Pb+1:0];
            quo_q <= {quo_q[Qb-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[Pb:0], num_q[Nb-1]};
            quo_q <= {quo_q[Qb-2:0], 1'b0};
          end
          if (step_q == 6'(Nb - 1)) state_q <= StFinish;
          step_q <= step_q + 1'b1;
        end
        StFinish: begin
          rsp_q <= '{kind: elrg_pkg::KindWave, period: '0, dropped: 1'b0,
                     wave: wv, last_of_period: last};
          if (last) begin
            pos_q <= '0;
            head_q <= head_q + 1'b1;
            fill_q <= fill_q - 1'b1;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
          state_q <= StOut;
        end
        StOut: begin
          if (!rsp_stall_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_IMPL(a_fill_range, 1'b1, fill_q <= (Aw+1)'(elrg_pkg::QueueDepth))
  `ASSERT_IMPL(a_wave_needs_fill, state_q == StFinish, fill_q != '0)
  `ASSERT_NEXT(a_pull_empty, accept && req_i.op == elrg_pkg::OpPull && fill_q == '0,
               state_q == StOut && rsp_q.kind == elrg_pkg::KindEmpty)

endmodule
